FILE: hw/rtl/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Shared constants, request and status codes, and the command and status
// structs that join the list controller to its datapath.
// ----------------------------------------------------------------------------
package idll_pkg;

	localparam int unsigned NODE_COUNT = 1024;
	localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
	localparam int unsigned SLOT_W     = IDX_W + 1;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned POS_W      = 10;
	localparam int unsigned REQ_W      = 3;
	localparam int unsigned STATUS_W   = 2;

	localparam int unsigned S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W = ((VALUE_W + 7) / 8) * 8;
	localparam int unsigned M_TUSER_W = 1 + STATUS_W;

	localparam logic [IDX_W-1:0]  HEAD_NODE  = '0;
	localparam logic [IDX_W-1:0]  TAIL_NODE  = IDX_W'(1);
	localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(NODE_COUNT);

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INS_LEFT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INS_RIGHT  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_READ_NEXT  = 3'd6;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

	localparam logic [1:0] CUR_HOLD = 2'd0;
	localparam logic [1:0] CUR_HEAD = 2'd1;
	localparam logic [1:0] CUR_NEXT = 2'd2;
	localparam logic [1:0] CUR_TAIL = 2'd3;

	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_BAD  = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;
	localparam logic [1:0] RES_EMIT = 2'd3;

	typedef struct packed {
		logic       load_req;
		logic       rd_cursor;
		logic [1:0] cur_op;
		logic       do_delete;
		logic       do_ins_node;
		logic       do_ins_link;
		logic       set_res;
		logic [1:0] res_op;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             pos_ok;
		logic             full;
		logic             cursor_tail;
		logic             cursor_live;
	} sts_t;

endpackage

FILE: hw/rtl/indexed_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Doubly linked list kept in fixed node memories with head and tail
// sentinels; supports inserts, deletes by ordinal and a front-to-back readout.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                          tuser                  tlast
//  s_axis    in         [9:0] position, [41:10] value  [2:0] req_type         -
//  m_axis    out        [31:0] value_out               [0] has_value,         is_last
//                                                      [2:1] status
//
// One request per transaction, one result per request. Each request starts in the
// controller's read state and, by its kind, passes evaluate, link update or a second
// read and evaluate, over the registered reads and writes on the node memories, before
// its result is staged and loaded into the output register. The next request is accepted
// only after that load. Reset takes effect at once: live marks above the slot counter are
// never consulted. A stalled result holds the next request before its output.
module indexed_doubly_linked_list (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [idll_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // position, value_in
	input  logic [idll_pkg::REQ_W-1:0]      s_axis_tuser,  // req_type
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [idll_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // value_out
	output logic [idll_pkg::M_TUSER_W-1:0]  m_axis_tuser,  // has_value, status
	output logic                            m_axis_tlast
);

	idll_pkg::cmd_t cmd;
	idll_pkg::sts_t sts;

	logic signed [idll_pkg::VALUE_W-1:0] value_out;
	logic                                has_value;
	logic [idll_pkg::STATUS_W-1:0]       status;

	idll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	idll_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (s_axis_tuser),
		.position  (s_axis_tdata[idll_pkg::POS_W-1:0]),
		.value_in  (s_axis_tdata[idll_pkg::POS_W +: idll_pkg::VALUE_W]),
		.value_out (value_out),
		.has_value (has_value),
		.is_last   (m_axis_tlast),
		.status    (status)
	);

	assign m_axis_tdata = idll_pkg::M_TDATA_W'(value_out);
	assign m_axis_tuser = {status, has_value};

endmodule

FILE: hw/rtl/idll_ram.sv
// ----------------------------------------------------------------------------
// idll_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module idll_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/idll_ctrl.sv
// ----------------------------------------------------------------------------
// idll_ctrl
// Request sequencer: walks each request through read, evaluate, link update
// and result hand-off, and drives the datapath by commands.
// ----------------------------------------------------------------------------
module idll_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  idll_pkg::sts_t  sts,
	output idll_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EV   = 3'd2;
	localparam logic [2:0] ST_LINK = 3'd3;
	localparam logic [2:0] ST_RD2  = 3'd4;
	localparam logic [2:0] ST_EV2  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_cursor = (sts.req == idll_pkg::REQ_READ_NEXT);
				if (sts.req == idll_pkg::REQ_READ_FIRST) begin
					cmd.cur_op = idll_pkg::CUR_HEAD;
					state_d    = ST_RD2;
				end else if (sts.req == idll_pkg::REQ_READ_NEXT && sts.cursor_tail) begin
					cmd.set_res = 1'b1;
					cmd.res_op  = idll_pkg::RES_ZERO;
					state_d     = ST_OUT;
				end else if (sts.req inside {idll_pkg::REQ_PUSH_FRONT, idll_pkg::REQ_PUSH_BACK,
						idll_pkg::REQ_DELETE, idll_pkg::REQ_INS_LEFT,
						idll_pkg::REQ_INS_RIGHT, idll_pkg::REQ_READ_NEXT}) begin
					state_d = ST_EV;
				end else begin
					cmd.set_res = 1'b1;
					cmd.res_op  = idll_pkg::RES_ZERO;
					state_d     = ST_OUT;
				end
			end
			ST_EV: begin
				cmd.set_res = 1'b1;
				cmd.res_op  = idll_pkg::RES_ZERO;
				state_d     = ST_OUT;
				case (sts.req)
					idll_pkg::REQ_PUSH_FRONT, idll_pkg::REQ_PUSH_BACK: begin
						if (sts.full) begin
							cmd.res_op = idll_pkg::RES_FULL;
						end else begin
							cmd.do_ins_node = 1'b1;
							state_d         = ST_LINK;
						end
					end
					idll_pkg::REQ_DELETE: begin
						if (!sts.pos_ok) begin
							cmd.res_op = idll_pkg::RES_BAD;
						end else begin
							cmd.do_delete = 1'b1;
						end
					end
					idll_pkg::REQ_INS_LEFT, idll_pkg::REQ_INS_RIGHT: begin
						if (!sts.pos_ok) begin
							cmd.res_op = idll_pkg::RES_BAD;
						end else if (sts.full) begin
							cmd.res_op = idll_pkg::RES_FULL;
						end else begin
							cmd.do_ins_node = 1'b1;
							state_d         = ST_LINK;
						end
					end
					idll_pkg::REQ_READ_NEXT: begin
						if (!sts.cursor_live) begin
							cmd.cur_op = idll_pkg::CUR_TAIL;
							cmd.res_op = idll_pkg::RES_BAD;
						end else begin
							cmd.set_res = 1'b0;
							cmd.cur_op  = idll_pkg::CUR_NEXT;
							state_d     = ST_RD2;
						end
					end
					default: begin
					end
				endcase
			end
			ST_LINK: begin
				cmd.do_ins_link = 1'b1;
				state_d         = ST_OUT;
			end
			ST_RD2: begin
				cmd.rd_cursor = 1'b1;
				state_d       = ST_EV2;
			end
			ST_EV2: begin
				cmd.set_res = 1'b1;
				cmd.res_op  = idll_pkg::RES_EMIT;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/idll_dp.sv
// ----------------------------------------------------------------------------
// idll_dp
// List datapath: node memories, sentinel link registers, slot counter,
// readout cursor, result staging and the output register.
// ----------------------------------------------------------------------------
module idll_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  idll_pkg::cmd_t                       cmd,
	output idll_pkg::sts_t                       sts,
	input  logic [idll_pkg::REQ_W-1:0]           req_type,
	input  logic [idll_pkg::POS_W-1:0]           position,
	input  logic signed [idll_pkg::VALUE_W-1:0]  value_in,
	output logic signed [idll_pkg::VALUE_W-1:0]  value_out,
	output logic                                 has_value,
	output logic                                 is_last,
	output logic [idll_pkg::STATUS_W-1:0]        status
);

	logic [idll_pkg::REQ_W-1:0]          req_q;
	logic [idll_pkg::SLOT_W-1:0]         node_q;
	logic signed [idll_pkg::VALUE_W-1:0] value_q;
	logic [idll_pkg::SLOT_W-1:0]         next_slot_q;
	logic [idll_pkg::IDX_W-1:0]          cursor_q;
	logic [idll_pkg::IDX_W-1:0]          head_right_q;
	logic [idll_pkg::IDX_W-1:0]          tail_left_q;
	logic [idll_pkg::IDX_W-1:0]          anchor_q;
	logic [idll_pkg::IDX_W-1:0]          succ_q;

	logic signed [idll_pkg::VALUE_W-1:0] res_value_q;
	logic                                res_has_q;
	logic                                res_last_q;
	logic [idll_pkg::STATUS_W-1:0]       res_status_q;

	logic [idll_pkg::IDX_W-1:0]   node_idx;
	logic [idll_pkg::IDX_W-1:0]   slot_idx;
	logic [idll_pkg::IDX_W-1:0]   rd_addr;
	logic [idll_pkg::IDX_W-1:0]   left_rd;
	logic [idll_pkg::IDX_W-1:0]   right_rd;
	logic [idll_pkg::VALUE_W-1:0] pay_rd;
	logic                         live_rd;
	logic [idll_pkg::IDX_W-1:0]   anchor_d;
	logic [idll_pkg::IDX_W-1:0]   succ_d;

	logic                         left_we;
	logic [idll_pkg::IDX_W-1:0]   left_waddr;
	logic [idll_pkg::IDX_W-1:0]   left_wdata;
	logic                         right_we;
	logic [idll_pkg::IDX_W-1:0]   right_waddr;
	logic [idll_pkg::IDX_W-1:0]   right_wdata;
	logic                         live_we;
	logic [idll_pkg::IDX_W-1:0]   live_waddr;
	logic                         live_wdata;

	assign node_idx = node_q[idll_pkg::IDX_W-1:0];
	assign slot_idx = next_slot_q[idll_pkg::IDX_W-1:0];
	assign rd_addr  = cmd.rd_cursor ? cursor_q : node_idx;

	assign sts.req         = req_q;
	assign sts.pos_ok      = (node_q >= idll_pkg::FIRST_SLOT) && (node_q < next_slot_q) && live_rd;
	assign sts.full        = (next_slot_q >= idll_pkg::SLOT_LIMIT);
	assign sts.cursor_tail = (cursor_q == idll_pkg::TAIL_NODE);
	assign sts.cursor_live = live_rd;

	always_comb begin
		case (req_q)
			idll_pkg::REQ_PUSH_FRONT: begin
				anchor_d = idll_pkg::HEAD_NODE;
				succ_d   = head_right_q;
			end
			idll_pkg::REQ_PUSH_BACK: begin
				anchor_d = tail_left_q;
				succ_d   = idll_pkg::TAIL_NODE;
			end
			idll_pkg::REQ_INS_LEFT: begin
				anchor_d = left_rd;
				succ_d   = node_idx;
			end
			default: begin
				anchor_d = node_idx;
				succ_d   = right_rd;
			end
		endcase
	end

	always_comb begin
		left_we     = 1'b0;
		left_waddr  = slot_idx;
		left_wdata  = anchor_d;
		right_we    = 1'b0;
		right_waddr = slot_idx;
		right_wdata = succ_d;
		live_we     = 1'b0;
		live_waddr  = slot_idx;
		live_wdata  = 1'b1;
		if (cmd.do_ins_node) begin
			left_we  = 1'b1;
			right_we = 1'b1;
			live_we  = 1'b1;
		end else if (cmd.do_ins_link) begin
			left_we     = (succ_q != idll_pkg::TAIL_NODE);
			left_waddr  = succ_q;
			left_wdata  = slot_idx;
			right_we    = (anchor_q != idll_pkg::HEAD_NODE);
			right_waddr = anchor_q;
			right_wdata = slot_idx;
		end else if (cmd.do_delete) begin
			left_we     = (right_rd != idll_pkg::TAIL_NODE);
			left_waddr  = right_rd;
			left_wdata  = left_rd;
			right_we    = (left_rd != idll_pkg::HEAD_NODE);
			right_waddr = left_rd;
			right_wdata = right_rd;
			live_we     = 1'b1;
			live_waddr  = node_idx;
			live_wdata  = 1'b0;
		end
	end

	idll_ram #(.WIDTH(idll_pkg::IDX_W), .DEPTH(idll_pkg::NODE_COUNT)) u_left_ram (
		.clk   (clk),
		.we    (left_we),
		.waddr (left_waddr),
		.wdata (left_wdata),
		.raddr (rd_addr),
		.rdata (left_rd)
	);

	idll_ram #(.WIDTH(idll_pkg::IDX_W), .DEPTH(idll_pkg::NODE_COUNT)) u_right_ram (
		.clk   (clk),
		.we    (right_we),
		.waddr (right_waddr),
		.wdata (right_wdata),
		.raddr (rd_addr),
		.rdata (right_rd)
	);

	idll_ram #(.WIDTH(idll_pkg::VALUE_W), .DEPTH(idll_pkg::NODE_COUNT)) u_payload_ram (
		.clk   (clk),
		.we    (cmd.do_ins_node),
		.waddr (slot_idx),
		.wdata (value_q),
		.raddr (rd_addr),
		.rdata (pay_rd)
	);

	idll_ram #(.WIDTH(1), .DEPTH(idll_pkg::NODE_COUNT)) u_live_ram (
		.clk   (clk),
		.we    (live_we),
		.waddr (live_waddr),
		.wdata (live_wdata),
		.raddr (rd_addr),
		.rdata (live_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q  <= idll_pkg::FIRST_SLOT;
			cursor_q     <= idll_pkg::TAIL_NODE;
			head_right_q <= idll_pkg::TAIL_NODE;
			tail_left_q  <= idll_pkg::HEAD_NODE;
		end else begin
			if (cmd.do_ins_link) begin
				next_slot_q <= next_slot_q + idll_pkg::SLOT_W'(1);
				if (succ_q == idll_pkg::TAIL_NODE) begin
					tail_left_q <= slot_idx;
				end
				if (anchor_q == idll_pkg::HEAD_NODE) begin
					head_right_q <= slot_idx;
				end
			end else if (cmd.do_delete) begin
				if (right_rd == idll_pkg::TAIL_NODE) begin
					tail_left_q <= left_rd;
				end
				if (left_rd == idll_pkg::HEAD_NODE) begin
					head_right_q <= right_rd;
				end
			end
			case (cmd.cur_op)
				idll_pkg::CUR_HEAD: cursor_q <= head_right_q;
				idll_pkg::CUR_NEXT: cursor_q <= right_rd;
				idll_pkg::CUR_TAIL: cursor_q <= idll_pkg::TAIL_NODE;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q   <= req_type;
			node_q  <= idll_pkg::SLOT_W'(position) + idll_pkg::SLOT_W'(1);
			value_q <= value_in;
		end
		if (cmd.do_ins_node) begin
			anchor_q <= anchor_d;
			succ_q   <= succ_d;
		end
		if (cmd.set_res) begin
			res_value_q  <= '0;
			res_has_q    <= 1'b0;
			res_last_q   <= 1'b0;
			res_status_q <= idll_pkg::STATUS_OK;
			case (cmd.res_op)
				idll_pkg::RES_BAD:  res_status_q <= idll_pkg::STATUS_BAD;
				idll_pkg::RES_FULL: res_status_q <= idll_pkg::STATUS_FULL;
				idll_pkg::RES_EMIT: begin
					if (cursor_q != idll_pkg::TAIL_NODE) begin
						res_value_q <= pay_rd;
						res_has_q   <= 1'b1;
						res_last_q  <= (right_rd == idll_pkg::TAIL_NODE);
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			value_out <= res_value_q;
			has_value <= res_has_q;
			is_last   <= res_last_q;
			status    <= res_status_q;
		end
	end

endmodule

FILE: hw/rtl/idll_chk.sv
// ----------------------------------------------------------------------------
// idll_chk
// Port-level checks for the linked list block, bound to the top level.
// ----------------------------------------------------------------------------
module idll_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [idll_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [idll_pkg::M_TUSER_W-1:0]  m_axis_tuser,
	input logic                            m_axis_tlast
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a transaction is in flight");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == idll_pkg::STATUS_OK)
		else $error("element result with a failing status");

	a_last_has_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("last flag without an element");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

endmodule

bind indexed_doubly_linked_list idll_chk u_idll_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_indexed_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// tb_indexed_doubly_linked_list
// Drives list requests over the input stream and checks every result against
// a behavioral copy of the node tables. A few directed transactions cover the
// empty list, bad positions, value extremes and a full readout. Random traffic
// then keeps the list short so that readouts reach the tail. The run ends by
// filling every slot and probing the full table.
// ----------------------------------------------------------------------------
module tb_indexed_doubly_linked_list;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [idll_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 18;

	typedef struct packed {
		logic [idll_pkg::VALUE_W-1:0]  value;
		logic                          has_value;
		logic                          is_last;
		logic [idll_pkg::STATUS_W-1:0] status;
	} list_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [idll_pkg::S_TDATA_W-1:0] s_axis_tdata;  // position, value_in
	logic [idll_pkg::REQ_W-1:0]     s_axis_tuser;  // req_type
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [idll_pkg::M_TDATA_W-1:0] m_axis_tdata;  // value_out
	logic [idll_pkg::M_TUSER_W-1:0] m_axis_tuser;  // has_value, status
	logic                           m_axis_tlast;

	// Predicted node tables, slot counter and readout cursor.
	logic [idll_pkg::IDX_W-1:0]   prev_of [idll_pkg::NODE_COUNT];
	logic [idll_pkg::IDX_W-1:0]   next_of [idll_pkg::NODE_COUNT];
	logic [idll_pkg::VALUE_W-1:0] stored  [idll_pkg::NODE_COUNT];
	bit                           live    [idll_pkg::NODE_COUNT];
	int                           free_slot;
	int                           cursor;
	int                           live_count;

	list_result_t expected_results [$];
	int           mismatches   = 0;
	int           quiet_cycles = 0;
	bit           no_idle      = 1'b0;

	indexed_doubly_linked_list dut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser,
		.m_axis_tlast
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic list_result_t element_at(int n);
		list_result_t res;
		res = '0;
		res.value = stored[n];
		res.has_value = 1'b1;
		res.is_last = (next_of[n] == idll_pkg::TAIL_NODE);
		return res;
	endfunction

	function automatic list_result_t list_apply(logic [idll_pkg::REQ_W-1:0] req,
			logic [idll_pkg::POS_W-1:0] pos, logic [idll_pkg::VALUE_W-1:0] val);
		list_result_t res;
		int node, anchor, succ, lft, rgt;
		res = '0;
		node = int'(pos) + 1;
		case (req)
			idll_pkg::REQ_PUSH_FRONT, idll_pkg::REQ_PUSH_BACK, idll_pkg::REQ_DELETE,
			idll_pkg::REQ_INS_LEFT, idll_pkg::REQ_INS_RIGHT: begin
				if (req != idll_pkg::REQ_PUSH_FRONT && req != idll_pkg::REQ_PUSH_BACK &&
						!(node < free_slot && live[node])) begin
					res.status = idll_pkg::STATUS_BAD;
				end else if (req == idll_pkg::REQ_DELETE) begin
					lft = prev_of[node];
					rgt = next_of[node];
					next_of[lft] = idll_pkg::IDX_W'(rgt);
					prev_of[rgt] = idll_pkg::IDX_W'(lft);
					live[node] = 1'b0;
					live_count--;
				end else if (free_slot >= idll_pkg::NODE_COUNT) begin
					res.status = idll_pkg::STATUS_FULL;
				end else begin
					case (req)
						idll_pkg::REQ_PUSH_FRONT: anchor = idll_pkg::HEAD_NODE;
						idll_pkg::REQ_PUSH_BACK:  anchor = prev_of[idll_pkg::TAIL_NODE];
						idll_pkg::REQ_INS_LEFT:   anchor = prev_of[node];
						default:                  anchor = node;
					endcase
					succ = next_of[anchor];
					stored[free_slot] = val;
					prev_of[free_slot] = idll_pkg::IDX_W'(anchor);
					next_of[free_slot] = idll_pkg::IDX_W'(succ);
					prev_of[succ] = idll_pkg::IDX_W'(free_slot);
					next_of[anchor] = idll_pkg::IDX_W'(free_slot);
					live[free_slot] = 1'b1;
					free_slot++;
					live_count++;
				end
			end
			idll_pkg::REQ_READ_FIRST: begin
				cursor = next_of[idll_pkg::HEAD_NODE];
				if (cursor != idll_pkg::TAIL_NODE) res = element_at(cursor);
			end
			idll_pkg::REQ_READ_NEXT: begin
				if (cursor != idll_pkg::TAIL_NODE) begin
					if (!live[cursor]) begin
						cursor = idll_pkg::TAIL_NODE;
						res.status = idll_pkg::STATUS_BAD;
					end else begin
						cursor = next_of[cursor];
						if (cursor != idll_pkg::TAIL_NODE) res = element_at(cursor);
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [idll_pkg::POS_W-1:0] pick_live_pos();
		int nodes [$];
		for (int n = idll_pkg::FIRST_SLOT; n < free_slot; n++) if (live[n]) nodes.push_back(n);
		if (nodes.size() == 0) return idll_pkg::POS_W'($urandom_range(1023, 0));
		return idll_pkg::POS_W'(nodes[$urandom_range(nodes.size() - 1, 0)] - 1);
	endfunction

	function automatic logic [idll_pkg::POS_W-1:0] pick_dead_pos();
		int gone [$];
		for (int n = idll_pkg::FIRST_SLOT; n < free_slot; n++) if (!live[n]) gone.push_back(n);
		case ($urandom_range(3, 0))
			0: return '0;
			1: return '1;
			2: begin
				if (free_slot < idll_pkg::NODE_COUNT)
					return idll_pkg::POS_W'($urandom_range(idll_pkg::NODE_COUNT - 2,
						free_slot - 1));
			end
			default: ;
		endcase
		if (gone.size() != 0)
			return idll_pkg::POS_W'(gone[$urandom_range(gone.size() - 1, 0)] - 1);
		return '0;
	endfunction

	task automatic send_req(logic [idll_pkg::REQ_W-1:0] req, logic [idll_pkg::POS_W-1:0] pos,
			logic [idll_pkg::VALUE_W-1:0] val);
		@(negedge clk);
		while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= idll_pkg::S_TDATA_W'({val, pos});
		s_axis_tuser <= req;
		@(posedge clk);
		while (s_axis_tready !== 1'b1) @(posedge clk);
		expected_results.push_back(list_apply(req, pos, val));
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, list_result_t want, list_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: want %h/%b/%b/%0d got %h/%b/%b/%0d", $time, what,
				want.value, want.has_value, want.is_last, want.status,
				got.value, got.has_value, got.is_last, got.status);
	endtask

	// One random transaction; an occasional complete front-to-back readout.
	task automatic one_random_item(bit fill_mode);
		int roll, del_cut;
		logic [idll_pkg::REQ_W-1:0] kind;
		logic [idll_pkg::POS_W-1:0] pos;
		roll = fill_mode ? $urandom_range(99, 30) : $urandom_range(99, 0);
		del_cut = fill_mode ? 5 : (live_count > 24 ? 40 : 15);
		pos = ($urandom_range(9, 0) == 0) ? pick_dead_pos() : pick_live_pos();
		if (!fill_mode && roll < 2 && live_count <= 40) begin
			send_req(idll_pkg::REQ_READ_FIRST, pos, $urandom());
			while (cursor != idll_pkg::TAIL_NODE)
				send_req(idll_pkg::REQ_READ_NEXT, pos, $urandom());
			send_req(idll_pkg::REQ_READ_NEXT, pos, $urandom());
		end else begin
			if (roll < 4) begin
				kind = REQ_UNUSED;
			end else if (roll < 24) begin
				kind = idll_pkg::REQ_READ_NEXT;
			end else if (roll < 30) begin
				kind = idll_pkg::REQ_READ_FIRST;
			end else if (roll < 30 + del_cut) begin
				kind = idll_pkg::REQ_DELETE;
				if (cursor != idll_pkg::TAIL_NODE && live[cursor] && $urandom_range(4, 0) == 0)
					pos = idll_pkg::POS_W'(cursor - 1);
			end else begin
				case ($urandom_range(3, 0))
					0:       kind = idll_pkg::REQ_PUSH_FRONT;
					1:       kind = idll_pkg::REQ_PUSH_BACK;
					2:       kind = idll_pkg::REQ_INS_LEFT;
					default: kind = idll_pkg::REQ_INS_RIGHT;
				endcase
			end
			send_req(kind, pos, $urandom());
		end
	endtask

	task automatic test_empty_list();
		send_req(idll_pkg::REQ_READ_FIRST, '0, '0);
		send_req(idll_pkg::REQ_READ_NEXT, '0, '0);
		send_req(idll_pkg::REQ_DELETE, 10'd1, '1);
		send_req(idll_pkg::REQ_INS_LEFT, '0, 32'h1234_5678);
		send_req(idll_pkg::REQ_INS_RIGHT, '1, 32'h8765_4321);
		send_req(REQ_UNUSED, '1, '1);
	endtask

	// Leaves the list as ordinals 3, 5, 1, 2, 4, 6.
	task automatic test_directed_inserts();
		send_req(idll_pkg::REQ_PUSH_FRONT, '0, 32'h7fff_ffff);
		send_req(idll_pkg::REQ_PUSH_BACK, '1, 32'h8000_0000);
		send_req(idll_pkg::REQ_PUSH_FRONT, 10'h2aa, '0);
		send_req(idll_pkg::REQ_PUSH_BACK, 10'h155, '1);
		send_req(idll_pkg::REQ_INS_LEFT, 10'd1, 32'h5555_aaaa);
		send_req(idll_pkg::REQ_INS_RIGHT, 10'd4, 32'haaaa_5555);
	endtask

	task automatic test_full_readout();
		send_req(idll_pkg::REQ_READ_FIRST, '0, '0);
		repeat (5) send_req(idll_pkg::REQ_READ_NEXT, '0, '0);
		send_req(idll_pkg::REQ_READ_NEXT, '0, '0);
	endtask

	// Deleting the node under the cursor makes the next readout step fail.
	task automatic test_delete_cases();
		send_req(idll_pkg::REQ_READ_FIRST, '0, '0);
		send_req(idll_pkg::REQ_DELETE, 10'd3, '0);
		send_req(idll_pkg::REQ_READ_NEXT, '0, '0);
		send_req(idll_pkg::REQ_DELETE, 10'd3, '0);
		send_req(idll_pkg::REQ_DELETE, 10'd6, '0);
		send_req(idll_pkg::REQ_INS_LEFT, 10'd6, 32'h0f0f_0f0f);
	endtask

	task automatic test_random_traffic(int count);
		for (int i = 0; i < count; i++) one_random_item(1'b0);
	endtask

	task automatic test_no_idle_stretch(int count);
		no_idle = 1'b1;
		test_random_traffic(count);
		no_idle = 1'b0;
	endtask

	// A bad position is reported ahead of a full table.
	task automatic test_table_full();
		while (free_slot < idll_pkg::NODE_COUNT) one_random_item(1'b1);
		send_req(idll_pkg::REQ_PUSH_FRONT, '0, $urandom());
		send_req(idll_pkg::REQ_PUSH_BACK, '1, $urandom());
		send_req(idll_pkg::REQ_INS_LEFT, pick_live_pos(), $urandom());
		send_req(idll_pkg::REQ_INS_RIGHT, pick_live_pos(), $urandom());
		send_req(idll_pkg::REQ_INS_RIGHT, pick_dead_pos(), $urandom());
		send_req(idll_pkg::REQ_DELETE, 10'd1022, '0);
		send_req(idll_pkg::REQ_DELETE, pick_live_pos(), '0);
		send_req(idll_pkg::REQ_PUSH_BACK, '0, $urandom());
		send_req(idll_pkg::REQ_READ_FIRST, '0, '0);
		send_req(idll_pkg::REQ_READ_NEXT, '0, '0);
	endtask

	always @(negedge clk) m_axis_tready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);

	always @(posedge clk) begin : check_results
		list_result_t got, want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got.value = m_axis_tdata[idll_pkg::VALUE_W-1:0];
			got.has_value = m_axis_tuser[0];
			got.status = m_axis_tuser[2:1];
			got.is_last = m_axis_tlast;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.value !== want.value || got.has_value !== want.has_value ||
						got.is_last !== want.is_last || got.status !== want.status)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		foreach (live[n]) begin
			live[n] = 1'b0;
			prev_of[n] = '0;
			next_of[n] = '0;
			stored[n] = '0;
		end
		next_of[idll_pkg::HEAD_NODE] = idll_pkg::TAIL_NODE;
		prev_of[idll_pkg::TAIL_NODE] = idll_pkg::HEAD_NODE;
		free_slot = idll_pkg::FIRST_SLOT;
		cursor = idll_pkg::TAIL_NODE;
		live_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_directed_inserts();
		test_full_readout();
		test_delete_cases();
		test_random_traffic(150);
		test_no_idle_stretch(80);
		wait_results_done();
		test_random_traffic(90);
		test_table_full();

		wait_results_done();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
